>>> rtl/core/rbkv_pkg.sv
// Package for the request body key/value parser: sizes, character codes,
// method codes, result kinds, keyword tables and the structs between modules.
// No dependencies.
package rbkv_pkg;

	localparam int PATH_BYTES = 32;
	localparam int BODY_BYTES = 65536;

	// One bank holds the raw value of the token being parsed.
	localparam int BANK_SIZE = (PATH_BYTES + 1) > 8 ? (PATH_BYTES + 1) : 8;
	localparam int BANK_AW   = $clog2(BANK_SIZE);
	localparam int CNT_W     = $clog2(BODY_BYTES);
	localparam int PL_W      = $clog2(PATH_BYTES + 1);

	localparam logic [CNT_W-1:0] BODY_LIMIT = CNT_W'(BODY_BYTES - 1);

	// Key bytes beyond six never match a keyword; a length of seven marks a dead key.
	localparam int         KEY_STORE = 6;
	localparam logic [2:0] KEY_FULL  = 3'd7;
	// The first seven value bytes are kept for the method compare.
	localparam int         SHADOW_DEPTH = 7;

	localparam logic [2:0] HDR_DONE = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [2:0] {
		METH_NONE   = 3'd0,
		METH_GET    = 3'd1,
		METH_POST   = 3'd2,
		METH_PUT    = 3'd3,
		METH_DELETE = 3'd4,
		METH_PATCH  = 3'd5
	} method_t;

	typedef enum logic {
		ITEM_PATH    = 1'b0,
		ITEM_SUMMARY = 1'b1
	} item_kind_t;

	// Words are packed with their first character in the lowest byte.
	localparam int          VERB_COUNT = 5;
	localparam logic [47:0] VERB_TEXT [VERB_COUNT] = '{
		48'h0000_0054_4547,  // GET
		48'h0000_5453_4F50,  // POST
		48'h0000_0054_5550,  // PUT
		48'h4554_454C_4544,  // DELETE
		48'h0048_4354_4150   // PATCH
	};
	localparam logic [2:0] VERB_LEN [VERB_COUNT] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd5};

	localparam logic [47:0] KEY_PATH       = 48'h0000_6874_6170;
	localparam logic [2:0]  KEY_PATH_LEN   = 3'd4;
	localparam logic [47:0] KEY_METHOD     = 48'h646F_6874_656D;
	localparam logic [2:0]  KEY_METHOD_LEN = 3'd6;

	typedef struct packed {
		logic               en;
		logic [BANK_AW:0]   addr;
		logic [7:0]         data;
	} bank_wr_t;

	typedef struct packed {
		logic            valid;
		logic            bank;
		logic            offset;
		logic [PL_W-1:0] length;
		logic            found;
		method_t         method;
	} emit_req_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// Compares the first n bytes of two packed words.
	function automatic logic text_match(input logic [47:0] have, input logic [47:0] want,
			input logic [2:0] n);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (k < int'(n) && have[8*k +: 8] != want[8*k +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	// The first verb in table order wins, so the scan runs from the end.
	function automatic method_t verb_code(input logic [47:0] have, input logic [2:0] n);
		method_t code;
		code = METH_NONE;
		for (int i = VERB_COUNT - 1; i >= 0; i--) begin
			if (n == VERB_LEN[i] && text_match(have, VERB_TEXT[i], n))
				code = method_t'(3'(i + 1));
		end
		return code;
	endfunction

endpackage

>>> rtl/core/request_body_key_value_parser.sv
// Request body key/value parser. Input beats are taken one per cycle while no
// read-out is running; the final beat of a request holds the input off while the
// saved path bytes and the summary beat leave, one result beat per cycle when
// the sink is ready. The first path byte passes through the bank memory's read
// register and then the output register; an empty path goes straight to the summary
// beat. Reset is asynchronous, active low, and clears all control state.
module request_body_key_value_parser import rbkv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] path_byte, [8] path_found,
	                               // [14:9] path_length, [17:15] method_code, [23:18] zero
	output logic        m_tuser,   // [0] item_kind
	output logic        m_tlast    // last_item
);

	logic      busy;
	logic      take;
	bank_wr_t  bank_wr;
	emit_req_t emit_req;

	assign s_tready = !busy;
	assign take     = s_tvalid && s_tready;

	rbkv_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (s_tdata),
		.end_of_request (s_tlast),
		.bank_wr        (bank_wr),
		.emit_req       (emit_req)
	);

	rbkv_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.bank_wr  (bank_wr),
		.emit_req (emit_req),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> rtl/core/rbkv_parser.sv
// Byte parser: header separator search, body tokenizer, key and value trim,
// and the saved path and method. Writes raw value bytes into the bank memory.
// Depends on rbkv_pkg.
module rbkv_parser import rbkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  logic [7:0] data_byte,
	input  logic      end_of_request,
	output bank_wr_t  bank_wr,
	output emit_req_t emit_req
);

	logic [2:0]       hdr_q, hdr_d;
	logic [CNT_W-1:0] body_cnt_q, body_cnt_d;
	logic             stopped_q, stopped_d;
	logic             in_value_q, in_value_d;
	logic [2:0]       key_len_q, key_len_d;
	logic             key_space_q, key_space_d;
	logic [CNT_W-1:0] val_trim_q, val_trim_d;
	logic [CNT_W-1:0] val_raw_q, val_raw_d;
	logic [7:0]       val_first_q, val_first_d;
	logic [7:0]       val_last_q, val_last_d;
	logic             saved_bank_q, saved_bank_d;
	logic             saved_off_q, saved_off_d;
	logic [PL_W-1:0]  saved_len_q, saved_len_d;
	logic             saved_found_q, saved_found_d;
	method_t          method_q, method_d;

	logic [7:0] key_q [KEY_STORE];
	logic [7:0] shadow_q [SHADOW_DEPTH];
	logic       key_we, sh_we;
	logic [2:0] key_widx, sh_widx;
	logic [47:0] key_word;
	logic [47:0] val_word;
	logic [7:0]  sh_view [SHADOW_DEPTH];

	always_comb begin
		for (int k = 0; k < KEY_STORE; k++)
			key_word[8*k +: 8] = key_q[k];
	end

	assign key_widx = key_len_q;
	assign sh_widx  = 3'(val_raw_q);

	// Value bytes as seen after this beat's write.
	always_comb begin
		for (int k = 0; k < SHADOW_DEPTH; k++)
			sh_view[k] = (sh_we && sh_widx == 3'(k)) ? data_byte : shadow_q[k];
	end

	always_comb begin
		logic            fin;
		logic            ws;
		logic            strip;
		logic [CNT_W-1:0] vlen;
		logic [2:0]      vlen_small;
		logic            fill;

		hdr_d         = hdr_q;
		body_cnt_d    = body_cnt_q;
		stopped_d     = stopped_q;
		in_value_d    = in_value_q;
		key_len_d     = key_len_q;
		key_space_d   = key_space_q;
		val_trim_d    = val_trim_q;
		val_raw_d     = val_raw_q;
		val_first_d   = val_first_q;
		val_last_d    = val_last_q;
		saved_bank_d  = saved_bank_q;
		saved_off_d   = saved_off_q;
		saved_len_d   = saved_len_q;
		saved_found_d = saved_found_q;
		method_d      = method_q;
		key_we        = 1'b0;
		sh_we         = 1'b0;
		bank_wr.en    = 1'b0;
		fill          = ~saved_bank_q;
		bank_wr.addr  = {fill, BANK_AW'(val_raw_q)};
		bank_wr.data  = data_byte;
		fin           = 1'b0;
		ws            = is_ws(data_byte);

		if (take && !stopped_q) begin
			if (hdr_q < HDR_DONE) begin
				if (data_byte == CH_NUL)
					stopped_d = 1'b1;
				else if ((hdr_q == 3'd0 || hdr_q == 3'd2) && data_byte == CH_CR)
					hdr_d = hdr_q + 3'd1;
				else if ((hdr_q == 3'd1 || hdr_q == 3'd3) && data_byte == CH_LF)
					hdr_d = hdr_q + 3'd1;
				else
					hdr_d = (data_byte == CH_CR) ? 3'd1 : 3'd0;
			end else if (data_byte == CH_NUL) begin
				fin       = 1'b1;
				stopped_d = 1'b1;
			end else begin
				if (data_byte == CH_COMMA) begin
					fin = 1'b1;
				end else if (!in_value_q) begin
					if (data_byte == CH_COLON) begin
						in_value_d = 1'b1;
					end else if (ws) begin
						if (key_len_q != 3'd0)
							key_space_d = 1'b1;
					end else if (key_space_q) begin
						// A space inside the key makes it match nothing.
						key_len_d   = KEY_FULL;
						key_space_d = 1'b0;
					end else if (key_len_q < KEY_FULL) begin
						key_we    = (key_len_q < 3'(KEY_STORE));
						key_len_d = key_len_q + 3'd1;
					end
				end else if (!(val_raw_q == '0 && ws)) begin
					bank_wr.en = (32'(val_raw_q) < BANK_SIZE);
					sh_we      = (32'(val_raw_q) < SHADOW_DEPTH);
					if (val_raw_q == '0)
						val_first_d = data_byte;
					val_raw_d = val_raw_q + 1'b1;
					if (!ws) begin
						val_trim_d = val_raw_q + 1'b1;
						val_last_d = data_byte;
					end
				end
				body_cnt_d = body_cnt_q + 1'b1;
				if (body_cnt_d == BODY_LIMIT) begin
					fin       = 1'b1;
					stopped_d = 1'b1;
				end
			end
		end

		if (take && end_of_request && !stopped_d && hdr_d == HDR_DONE)
			fin = 1'b1;

		strip = (val_trim_d >= CNT_W'(2)) && (val_first_d == CH_QUOTE)
			&& (val_last_d == CH_QUOTE);
		vlen       = val_trim_d - {{(CNT_W-2){1'b0}}, strip, 1'b0};
		vlen_small = (vlen <= CNT_W'(6)) ? 3'(vlen) : KEY_FULL;
		for (int k = 0; k < 6; k++)
			val_word[8*k +: 8] = strip ? sh_view[k+1] : sh_view[k];

		if (fin) begin
			if (in_value_d) begin
				if (key_len_d == KEY_PATH_LEN && text_match(key_word, KEY_PATH, KEY_PATH_LEN)) begin
					saved_bank_d  = fill;
					saved_off_d   = strip;
					saved_len_d   = (32'(vlen) > PATH_BYTES) ? PL_W'(PATH_BYTES) : PL_W'(vlen);
					saved_found_d = 1'b1;
				end else if (key_len_d == KEY_METHOD_LEN
						&& text_match(key_word, KEY_METHOD, KEY_METHOD_LEN)) begin
					if (verb_code(val_word, vlen_small) != METH_NONE)
						method_d = verb_code(val_word, vlen_small);
				end
			end
			in_value_d  = 1'b0;
			key_len_d   = 3'd0;
			key_space_d = 1'b0;
			val_trim_d  = '0;
			val_raw_d   = '0;
			val_first_d = '0;
			val_last_d  = '0;
		end

		emit_req.valid  = take && end_of_request;
		emit_req.bank   = saved_bank_d;
		emit_req.offset = saved_off_d;
		emit_req.length = saved_found_d ? saved_len_d : '0;
		emit_req.found  = saved_found_d;
		emit_req.method = method_d;

		// The last beat of a request returns everything to its reset value.
		if (take && end_of_request) begin
			hdr_d         = '0;
			body_cnt_d    = '0;
			stopped_d     = 1'b0;
			in_value_d    = 1'b0;
			key_len_d     = '0;
			key_space_d   = 1'b0;
			val_trim_d    = '0;
			val_raw_d     = '0;
			val_first_d   = '0;
			val_last_d    = '0;
			saved_bank_d  = 1'b0;
			saved_off_d   = 1'b0;
			saved_len_d   = '0;
			saved_found_d = 1'b0;
			method_d      = METH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q         <= '0;
			body_cnt_q    <= '0;
			stopped_q     <= 1'b0;
			in_value_q    <= 1'b0;
			key_len_q     <= '0;
			key_space_q   <= 1'b0;
			val_trim_q    <= '0;
			val_raw_q     <= '0;
			val_first_q   <= '0;
			val_last_q    <= '0;
			saved_bank_q  <= 1'b0;
			saved_off_q   <= 1'b0;
			saved_len_q   <= '0;
			saved_found_q <= 1'b0;
			method_q      <= METH_NONE;
		end else begin
			hdr_q         <= hdr_d;
			body_cnt_q    <= body_cnt_d;
			stopped_q     <= stopped_d;
			in_value_q    <= in_value_d;
			key_len_q     <= key_len_d;
			key_space_q   <= key_space_d;
			val_trim_q    <= val_trim_d;
			val_raw_q     <= val_raw_d;
			val_first_q   <= val_first_d;
			val_last_q    <= val_last_d;
			saved_bank_q  <= saved_bank_d;
			saved_off_q   <= saved_off_d;
			saved_len_q   <= saved_len_d;
			saved_found_q <= saved_found_d;
			method_q      <= method_d;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_q[key_widx] <= data_byte;
		if (sh_we)
			shadow_q[sh_widx] <= data_byte;
	end

endmodule

>>> rtl/core/rbkv_emitter.sv
// Value bank memory, path read-out sequencer and the output register.
// Streams the saved path bytes and then the summary beat.
// Depends on rbkv_pkg.
module rbkv_emitter import rbkv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bank_wr_t   bank_wr,
	input  emit_req_t  emit_req,
	output logic       busy,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [23:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);

	localparam int MEM_DEPTH = 2 * (2 ** BANK_AW);

	logic [7:0] mem [MEM_DEPTH];

	logic            busy_q;
	logic            bank_q;
	logic            off_q;
	logic [PL_W-1:0] len_q;
	logic            found_q;
	method_t         method_q;
	logic [PL_W-1:0] idx_q;
	logic            rvalid_q;
	logic [7:0]      rdata_q;

	logic            ovalid_q;
	item_kind_t      okind_q;
	logic [7:0]      obyte_q;
	logic            ofound_q;
	logic [PL_W-1:0] olen_q;
	method_t         ometh_q;
	logic            olast_q;

	logic             out_free;
	logic             issue;
	logic             load_byte;
	logic             load_sum;
	logic [BANK_AW:0] rd_addr;

	assign out_free  = !ovalid_q || m_tready;
	// A read is issued only when its data has somewhere to go next cycle.
	assign issue     = busy_q && (idx_q != len_q) && (!rvalid_q || out_free);
	assign load_byte = out_free && rvalid_q;
	assign load_sum  = busy_q && out_free && !rvalid_q && (idx_q == len_q);
	assign rd_addr   = {bank_q, BANK_AW'(off_q) + BANK_AW'(idx_q)};

	always_ff @(posedge clk) begin
		if (bank_wr.en)
			mem[bank_wr.addr] <= bank_wr.data;
		if (issue)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			rvalid_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit_req.valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (load_sum)
					busy_q <= 1'b0;
				if (issue)
					idx_q <= idx_q + 1'b1;
			end
			if (issue)
				rvalid_q <= 1'b1;
			else if (load_byte)
				rvalid_q <= 1'b0;
			if (load_byte || load_sum)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req.valid) begin
			bank_q   <= emit_req.bank;
			off_q    <= emit_req.offset;
			len_q    <= emit_req.length;
			found_q  <= emit_req.found;
			method_q <= emit_req.method;
		end
		if (load_byte) begin
			okind_q  <= ITEM_PATH;
			obyte_q  <= rdata_q;
			ofound_q <= 1'b0;
			olen_q   <= '0;
			ometh_q  <= METH_NONE;
			olast_q  <= 1'b0;
		end else if (load_sum) begin
			okind_q  <= ITEM_SUMMARY;
			obyte_q  <= '0;
			ofound_q <= found_q;
			olen_q   <= len_q;
			ometh_q  <= method_q;
			olast_q  <= 1'b1;
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = ovalid_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {6'd0, ometh_q, 6'(olen_q), ofound_q, obyte_q};

endmodule
